FILE: rtl/bth_pkg.sv
package bth_pkg;

	// fixed field widths of the ports and of the tag word
	localparam int FIELD_W = 16;
	localparam int OP_W    = 2;
	localparam int TAG_W   = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

	// boundary tag constants
	localparam logic [TAG_W-1:0] TAG_USED = 32'h1;
	localparam logic [TAG_W-1:0] TAG_PRO  = 32'h9;
	localparam logic [TAG_W-1:0] TAG_EPI  = 32'h1;
	localparam logic [TAG_W-1:0] TAG_ZERO = 32'h0;

	// datapath commands, one per controller step
	typedef enum logic [5:0] {
		C_NOP,
		C_INIT,
		C_LOAD,
		C_SH,
		C_SF,
		C_FR0,
		C_FR1,
		C_MG0,
		C_MG1,
		C_MG2,
		C_MG3,
		C_MG4,
		C_MG5,
		C_RS0,
		C_RS1,
		C_RES_A,
		C_SHR1,
		C_SHR2,
		C_SHR3,
		C_RD_NXT,
		C_RG0,
		C_RG1,
		C_RG3,
		C_RG4,
		C_AL0,
		C_WISS,
		C_WALK,
		C_PL_BEST,
		C_FULL,
		C_EXT1,
		C_EXT2,
		C_PL0,
		C_PL1,
		C_PL_WHOLE,
		C_PL_SPLIT,
		C_PL3,
		C_ALD,
		C_ALD_MV
	} dp_cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            size_zero;
		logic            addr_zero;
		logic            init_last;
		logic            walk_out;
		logic            walk_stop;
		logic            best_zero;
		logic            heap_full;
		logic            rs_eq;
		logic            rs_lt;
		logic            rs_big;
		logic            grow_ok;
		logic            whole;
		logic            pu;
		logic            nu;
	} dp_stat_t;

endpackage

FILE: rtl/boundary_tag_heap_allocator.sv
// Channel   Handshake            Payload
// request   start & !busy        operation, request_size, block_address
// result    done (one cycle)     result_address, status, moved
//
// After reset the block writes four tag words (a zero pad word, the
// prologue header and footer, and the epilogue) and holds busy high.
// An allocate walks the block list with one store read per block header,
// then places the block and writes its tags.
// A moving resize adds an allocate and a free to the resize.
// The result strobe cannot be held off; busy stays high until it is shown.
module boundary_tag_heap_allocator #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bth_pkg::OP_W-1:0]    operation,
	input  logic [bth_pkg::FIELD_W-1:0] request_size,
	input  logic [bth_pkg::FIELD_W-1:0] block_address,
	output logic                        done,
	output logic [bth_pkg::FIELD_W-1:0] result_address,
	output logic                        status,
	output logic                        moved
);
	import bth_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	// sequence requests
	bth_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// tag store and arithmetic
	bth_dpath #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operation      (operation),
		.request_size   (request_size),
		.block_address  (block_address),
		.st             (st),
		.result_address (result_address),
		.status         (status),
		.moved          (moved)
	);

endmodule

FILE: rtl/bth_dpath.sv
module bth_dpath #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bth_pkg::dp_cmd_t            cmd,
	input  logic [bth_pkg::OP_W-1:0]    operation,
	input  logic [bth_pkg::FIELD_W-1:0] request_size,
	input  logic [bth_pkg::FIELD_W-1:0] block_address,
	output bth_pkg::dp_stat_t           st,
	output logic [bth_pkg::FIELD_W-1:0] result_address,
	output logic                        status,
	output logic                        moved
);
	import bth_pkg::*;

	localparam int AW    = $clog2(HEAP_BYTES);
	localparam int IW    = AW - 2;
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int W     = AW + 34;
	localparam int BW    = AW + 1;
	localparam int LIMIT = HEAP_BYTES / 8 + 2;
	localparam int CW    = $clog2(LIMIT + 1);
	localparam int NW    = FIELD_W + 1;

	function automatic logic [IW-1:0] widx(input logic [W-1:0] b);
		return b[AW-1:2];
	endfunction

	function automatic logic [W-1:0] tsize(input logic [TAG_W-1:0] t);
		return W'({t[TAG_W-1:3], 3'b000});
	endfunction

	// tag store and its registered read
	logic [TAG_W-1:0] mem [DEPTH];
	logic [TAG_W-1:0] rd_q;
	logic [IW-1:0]    raddr;
	logic [IW-1:0]    waddr;
	logic [TAG_W-1:0] wdata;
	logic             we;

	// request and walk registers
	logic [OP_W-1:0]    op_q;
	logic [FIELD_W-1:0] sz_q;
	logic [FIELD_W-1:0] a_q;
	logic [NW-1:0]      need_q;
	logic [W-1:0]       p_q, best_q, gap_q;
	logic [CW-1:0]      cnt_q;
	logic [BW-1:0]      brk_q;
	logic [1:0]         ic_q;
	logic [W-1:0]       old_q, nx_q, fp_q, pre_q;
	logic [W-1:0]       psz_q, prsz_q, nsz_q, bs_q;
	logic               pu_q, nu_q;
	logic [W-1:0]       pp_q, pn_q, tp_q;
	logic [TAG_W-1:0]   tt_q;
	logic [FIELD_W-1:0] res_q;
	logic               full_q, moved_q;

	logic [NW-1:0] need_d;
	logic [W-1:0]  a_w, need_w, brk_w, rd_sz;
	logic          wk_end, wk_cand, wk_better;
	logic [W-1:0]  wk_gap;
	logic [W-1:0]  ms_a, ms_b, ms_c, on_diff, bs_diff, grow_sz;

	assign need_d  = (NW'(sz_q) + NW'(15)) & ~NW'(7);
	assign a_w     = W'(a_q);
	assign need_w  = W'(need_q);
	assign brk_w   = W'(brk_q);
	assign rd_sz   = tsize(rd_q);
	assign ms_a    = psz_q + nsz_q;
	assign ms_b    = psz_q + prsz_q;
	assign ms_c    = ms_b + nsz_q;
	assign on_diff = old_q - need_w;
	assign bs_diff = bs_q - pn_q;
	assign grow_sz = old_q + rd_sz;

	// compare one walked block against the best so far
	assign wk_end    = (rd_q == TAG_EPI) || (rd_sz == '0);
	assign wk_cand   = !rd_q[0] && (need_w <= rd_sz);
	assign wk_gap    = rd_sz - need_w;
	assign wk_better = (best_q == '0) || (wk_gap < gap_q);

	// status toward the controller
	always_comb begin
		st.op        = op_q;
		st.size_zero = (sz_q == '0);
		st.addr_zero = (a_q == '0);
		st.init_last = (ic_q == 2'd3);
		st.walk_out  = (p_q > brk_w) || (cnt_q == CW'(LIMIT));
		st.walk_stop = wk_end || (wk_cand && wk_better && (wk_gap == '0));
		st.best_zero = (best_q == '0);
		st.heap_full = (brk_w + need_w) > W'(HEAP_BYTES);
		st.rs_eq     = (old_q == need_w);
		st.rs_lt     = (need_w < old_q);
		st.rs_big    = (on_diff >= W'(16));
		st.grow_ok   = !nu_q && ((old_q + nsz_q) >= need_w);
		st.whole     = (pn_q > bs_q) || (bs_diff < W'(16));
		st.pu        = pu_q;
		st.nu        = nu_q;
	end

	// select the read address
	always_comb begin
		raddr = '0;
		unique case (cmd)
			C_FR0, C_RS0: raddr = widx(a_w - W'(4));
			C_MG0:        raddr = widx(fp_q - W'(8));
			C_MG1:        raddr = widx(fp_q - W'(4));
			C_MG2:        raddr = widx(pre_q - W'(4));
			C_MG3, C_RG3: raddr = widx(nx_q - W'(4));
			C_RD_NXT:     raddr = widx(a_w + old_q - W'(4));
			C_WISS:       raddr = widx(p_q - W'(4));
			C_PL0:        raddr = widx(pp_q - W'(4));
			default:      raddr = '0;
		endcase
	end

	// select the write port
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (cmd)
			C_INIT: begin
				we    = 1'b1;
				waddr = IW'(ic_q);
				unique case (ic_q)
					2'd0:         wdata = TAG_ZERO;
					2'd1, 2'd2:   wdata = TAG_PRO;
					default:      wdata = TAG_EPI;
				endcase
			end
			C_SH: begin
				we    = 1'b1;
				waddr = widx(tp_q - W'(4));
				wdata = tt_q;
			end
			C_SF: begin
				we    = 1'b1;
				waddr = widx(tp_q + tsize(tt_q) - W'(8));
				wdata = tt_q;
			end
			C_EXT1: begin
				we    = 1'b1;
				waddr = widx(brk_w + need_w - W'(4));
				wdata = TAG_EPI;
			end
			default: we = 1'b0;
		endcase
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// break and init counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_q <= BW'(16);
			ic_q  <= 2'd0;
		end else begin
			if (cmd == C_INIT) begin
				ic_q <= ic_q + 2'd1;
			end
			if (cmd == C_EXT2) begin
				brk_q <= BW'(brk_w + need_w);
			end
		end
	end

	// step the working registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			C_LOAD: begin
				op_q    <= operation;
				sz_q    <= request_size;
				a_q     <= block_address;
				res_q   <= '0;
				full_q  <= 1'b0;
				moved_q <= 1'b0;
			end
			C_FR0: fp_q <= a_w;
			C_FR1: begin
				tp_q <= fp_q;
				tt_q <= {rd_q[TAG_W-1:3], 3'b000};
			end
			C_MG1: pre_q <= fp_q - rd_sz;
			C_MG2: begin
				psz_q <= rd_sz;
				nx_q  <= fp_q + rd_sz;
			end
			C_MG3: begin
				pu_q   <= rd_q[0];
				prsz_q <= rd_sz;
			end
			C_MG4, C_RG0: begin
				nu_q  <= rd_q[0];
				nsz_q <= rd_sz;
			end
			C_MG5: begin
				priority if (pu_q) begin
					tp_q <= fp_q;
					tt_q <= ms_a[TAG_W-1:0];
				end else if (nu_q) begin
					tp_q <= pre_q;
					tt_q <= ms_b[TAG_W-1:0];
				end else begin
					tp_q <= pre_q;
					tt_q <= ms_c[TAG_W-1:0];
				end
			end
			C_RS0: need_q <= need_d;
			C_RS1: old_q <= rd_sz;
			C_RES_A: res_q <= a_q;
			C_SHR1: begin
				res_q <= a_q;
				tp_q  <= a_w;
				tt_q  <= TAG_W'(need_q) | TAG_USED;
			end
			C_SHR2: begin
				tp_q <= a_w + need_w;
				tt_q <= on_diff[TAG_W-1:0];
			end
			C_SHR3: fp_q <= a_w + need_w;
			C_RD_NXT: nx_q <= a_w + old_q;
			C_RG1: begin
				pp_q <= nx_q;
				pn_q <= need_w - old_q;
			end
			C_RG4: begin
				tp_q  <= a_w;
				tt_q  <= grow_sz[TAG_W-1:0] | TAG_USED;
				res_q <= a_q;
			end
			C_AL0: begin
				need_q <= need_d;
				p_q    <= W'(8);
				best_q <= '0;
				gap_q  <= '0;
				cnt_q  <= '0;
			end
			C_WALK: begin
				if (!wk_end) begin
					if (wk_cand && wk_better) begin
						gap_q  <= wk_gap;
						best_q <= p_q;
					end
					p_q   <= p_q + rd_sz;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			C_PL_BEST: begin
				pp_q <= best_q;
				pn_q <= need_w;
			end
			C_FULL: begin
				full_q <= 1'b1;
				res_q  <= '0;
			end
			C_EXT1: begin
				pp_q <= brk_w;
				pn_q <= need_w;
			end
			C_EXT2: begin
				tp_q <= brk_w;
				tt_q <= TAG_W'(need_q);
			end
			C_PL1: bs_q <= rd_sz;
			C_PL_WHOLE: begin
				tp_q <= pp_q;
				tt_q <= bs_q[TAG_W-1:0] | TAG_USED;
			end
			C_PL_SPLIT: begin
				tp_q <= pp_q;
				tt_q <= pn_q[TAG_W-1:0] | TAG_USED;
			end
			C_PL3: begin
				tp_q <= pp_q + pn_q;
				tt_q <= bs_diff[TAG_W-1:0];
			end
			C_ALD: res_q <= pp_q[FIELD_W-1:0];
			C_ALD_MV: begin
				res_q   <= pp_q[FIELD_W-1:0];
				moved_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_address = res_q;
	assign status         = full_q;
	assign moved          = moved_q;

	a_brk_align: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q[2:0] == 3'b000) else $error("break not 8-byte aligned");
	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_w <= W'(HEAP_BYTES)) else $error("break past heap end");
	a_brk_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> brk_q >= $past(brk_q)) else $error("break moved back");

endmodule

FILE: rtl/bth_ctrl.sv
module bth_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bth_pkg::dp_stat_t st,
	output bth_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import bth_pkg::*;

	localparam int ST_W = 35;

	typedef enum logic [ST_W-1:0] {
		S_INIT = ST_W'(1) << 0,
		S_IDLE = ST_W'(1) << 1,
		S_DISP = ST_W'(1) << 2,
		S_FIN  = ST_W'(1) << 3,
		S_SH   = ST_W'(1) << 4,
		S_SF   = ST_W'(1) << 5,
		S_FR0  = ST_W'(1) << 6,
		S_FR1  = ST_W'(1) << 7,
		S_MG0  = ST_W'(1) << 8,
		S_MG1  = ST_W'(1) << 9,
		S_MG2  = ST_W'(1) << 10,
		S_MG3  = ST_W'(1) << 11,
		S_MG4  = ST_W'(1) << 12,
		S_MG5  = ST_W'(1) << 13,
		S_RS0  = ST_W'(1) << 14,
		S_RS1  = ST_W'(1) << 15,
		S_RS2  = ST_W'(1) << 16,
		S_RSH2 = ST_W'(1) << 17,
		S_RSH3 = ST_W'(1) << 18,
		S_RG0  = ST_W'(1) << 19,
		S_RG1  = ST_W'(1) << 20,
		S_RG3  = ST_W'(1) << 21,
		S_RG4  = ST_W'(1) << 22,
		S_AL0  = ST_W'(1) << 23,
		S_WCHK = ST_W'(1) << 24,
		S_WRD  = ST_W'(1) << 25,
		S_WEND = ST_W'(1) << 26,
		S_EXT1 = ST_W'(1) << 27,
		S_EXT2 = ST_W'(1) << 28,
		S_PL0  = ST_W'(1) << 29,
		S_PL1  = ST_W'(1) << 30,
		S_PL2  = ST_W'(1) << 31,
		S_PL3  = ST_W'(1) << 32,
		S_PLR  = ST_W'(1) << 33,
		S_ALD  = ST_W'(1) << 34
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   plc_q, plc_d;
	logic   alc_q, alc_d;

	// sequence the request through its micro-steps
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		plc_d   = plc_q;
		alc_d   = alc_q;
		cmd     = C_NOP;
		unique case (state_q)
			S_INIT: begin
				cmd = C_INIT;
				if (st.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd     = C_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				alc_d = 1'b0;
				priority if (st.op == OP_ALLOC) begin
					state_d = st.size_zero ? S_FIN : S_AL0;
				end else if (st.op == OP_FREE) begin
					state_d = st.addr_zero ? S_FIN : S_FR0;
				end else if (st.op == OP_RESIZE) begin
					priority if (st.size_zero) state_d = st.addr_zero ? S_FIN : S_FR0;
					else if (st.addr_zero) state_d = S_AL0;
					else state_d = S_RS0;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_IDLE;
			S_SH: begin
				cmd     = C_SH;
				state_d = S_SF;
			end
			S_SF: begin
				cmd     = C_SF;
				state_d = ret_q;
			end
			S_FR0: begin
				cmd     = C_FR0;
				state_d = S_FR1;
			end
			S_FR1: begin
				cmd     = C_FR1;
				ret_d   = S_MG0;
				state_d = S_SH;
			end
			S_MG0: begin
				cmd     = C_MG0;
				state_d = S_MG1;
			end
			S_MG1: begin
				cmd     = C_MG1;
				state_d = S_MG2;
			end
			S_MG2: begin
				cmd     = C_MG2;
				state_d = S_MG3;
			end
			S_MG3: begin
				cmd     = C_MG3;
				state_d = S_MG4;
			end
			S_MG4: begin
				cmd     = C_MG4;
				state_d = S_MG5;
			end
			S_MG5: begin
				if (st.pu && st.nu) begin
					state_d = S_FIN;
				end else begin
					cmd     = C_MG5;
					ret_d   = S_FIN;
					state_d = S_SH;
				end
			end
			S_RS0: begin
				cmd     = C_RS0;
				state_d = S_RS1;
			end
			S_RS1: begin
				cmd     = C_RS1;
				state_d = S_RS2;
			end
			S_RS2: begin
				priority if (st.rs_eq) begin
					cmd     = C_RES_A;
					state_d = S_FIN;
				end else if (st.rs_lt && st.rs_big) begin
					cmd     = C_SHR1;
					ret_d   = S_RSH2;
					state_d = S_SH;
				end else if (st.rs_lt) begin
					cmd     = C_RES_A;
					state_d = S_FIN;
				end else begin
					cmd     = C_RD_NXT;
					state_d = S_RG0;
				end
			end
			S_RSH2: begin
				cmd     = C_SHR2;
				ret_d   = S_RSH3;
				state_d = S_SH;
			end
			S_RSH3: begin
				cmd     = C_SHR3;
				state_d = S_MG0;
			end
			S_RG0: begin
				cmd     = C_RG0;
				state_d = S_RG1;
			end
			S_RG1: begin
				if (st.grow_ok) begin
					cmd     = C_RG1;
					plc_d   = 1'b1;
					state_d = S_PL0;
				end else begin
					alc_d   = 1'b1;
					state_d = S_AL0;
				end
			end
			S_RG3: begin
				cmd     = C_RG3;
				state_d = S_RG4;
			end
			S_RG4: begin
				cmd     = C_RG4;
				ret_d   = S_FIN;
				state_d = S_SH;
			end
			S_AL0: begin
				cmd     = C_AL0;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (st.walk_out) begin
					state_d = S_WEND;
				end else begin
					cmd     = C_WISS;
					state_d = S_WRD;
				end
			end
			S_WRD: begin
				cmd     = C_WALK;
				state_d = st.walk_stop ? S_WEND : S_WCHK;
			end
			S_WEND: begin
				priority if (!st.best_zero) begin
					cmd     = C_PL_BEST;
					plc_d   = 1'b0;
					state_d = S_PL0;
				end else if (st.heap_full) begin
					cmd     = C_FULL;
					state_d = S_FIN;
				end else begin
					cmd     = C_EXT1;
					state_d = S_EXT2;
				end
			end
			S_EXT2: begin
				cmd     = C_EXT2;
				plc_d   = 1'b0;
				ret_d   = S_PL0;
				state_d = S_SH;
			end
			S_PL0: begin
				cmd     = C_PL0;
				state_d = S_PL1;
			end
			S_PL1: begin
				cmd     = C_PL1;
				state_d = S_PL2;
			end
			S_PL2: begin
				if (st.whole) begin
					cmd   = C_PL_WHOLE;
					ret_d = S_PLR;
				end else begin
					cmd   = C_PL_SPLIT;
					ret_d = S_PL3;
				end
				state_d = S_SH;
			end
			S_PL3: begin
				cmd     = C_PL3;
				ret_d   = S_PLR;
				state_d = S_SH;
			end
			S_PLR: state_d = plc_q ? S_RG3 : S_ALD;
			S_ALD: begin
				if (alc_q) begin
					cmd     = C_ALD_MV;
					state_d = S_FR0;
				end else begin
					cmd     = C_ALD;
					state_d = S_FIN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and return context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_FIN;
			plc_q   <= 1'b0;
			alc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			plc_q   <= plc_d;
			alc_q   <= alc_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not idle after result");

endmodule
